@@ sv/stellar_class_string_parser_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Stellar class string parser assertion macros
// Shared property wrappers for the checker of the parser unit.
// ----------------------------------------------------------------------------
`ifndef STELLAR_CLASS_STRING_PARSER_UNIT_MACROS_SVH
`define STELLAR_CLASS_STRING_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define SCSP_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scsp assertion failed");

// next-cycle implication
`define SCSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scsp assertion failed");

`endif

@@ sv/scsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Stellar class string parser package
// Word types, parser state record and the class code constants.
// ----------------------------------------------------------------------------
package scsp_pkg;

   // stellar type codes
   localparam logic [1:0] TYPE_NORMAL      = 2'd0;
   localparam logic [1:0] TYPE_WHITE_DWARF = 2'd1;
   localparam logic [1:0] TYPE_NEUTRON     = 2'd2;
   localparam logic [1:0] TYPE_BLACK_HOLE  = 2'd3;

   // spectral class codes
   localparam logic [4:0] SPEC_UNKNOWN = 5'd0;
   localparam logic [4:0] SPEC_O  = 5'd1;
   localparam logic [4:0] SPEC_B  = 5'd2;
   localparam logic [4:0] SPEC_A  = 5'd3;
   localparam logic [4:0] SPEC_F  = 5'd4;
   localparam logic [4:0] SPEC_G  = 5'd5;
   localparam logic [4:0] SPEC_K  = 5'd6;
   localparam logic [4:0] SPEC_M  = 5'd7;
   localparam logic [4:0] SPEC_R  = 5'd8;
   localparam logic [4:0] SPEC_N  = 5'd9;
   localparam logic [4:0] SPEC_C  = 5'd10;
   localparam logic [4:0] SPEC_S  = 5'd11;
   localparam logic [4:0] SPEC_WO = 5'd12;
   localparam logic [4:0] SPEC_WN = 5'd13;
   localparam logic [4:0] SPEC_WC = 5'd14;
   localparam logic [4:0] SPEC_L  = 5'd15;
   localparam logic [4:0] SPEC_T  = 5'd16;
   localparam logic [4:0] SPEC_Y  = 5'd17;
   localparam logic [4:0] SPEC_D  = 5'd18;
   localparam logic [4:0] SPEC_DA = 5'd19;
   localparam logic [4:0] SPEC_DB = 5'd20;
   localparam logic [4:0] SPEC_DC = 5'd21;
   localparam logic [4:0] SPEC_DO = 5'd22;
   localparam logic [4:0] SPEC_DQ = 5'd23;
   localparam logic [4:0] SPEC_DX = 5'd24;
   localparam logic [4:0] SPEC_DZ = 5'd25;

   // luminosity class codes
   localparam logic [3:0] LUM_UNKNOWN = 4'd0;
   localparam logic [3:0] LUM_ZERO    = 4'd1;
   localparam logic [3:0] LUM_IA_PLUS = 4'd2;
   localparam logic [3:0] LUM_IA      = 4'd3;
   localparam logic [3:0] LUM_IAB     = 4'd4;
   localparam logic [3:0] LUM_IB      = 4'd5;
   localparam logic [3:0] LUM_I       = 4'd6;
   localparam logic [3:0] LUM_II      = 4'd7;
   localparam logic [3:0] LUM_III     = 4'd8;
   localparam logic [3:0] LUM_IV      = 4'd9;
   localparam logic [3:0] LUM_V       = 4'd10;
   localparam logic [3:0] LUM_VI      = 4'd11;

   localparam logic [6:0] SUBCLASS_MAX = 7'd99;

   typedef enum logic [16:0] {
      PH_BEGIN    = 17'h00001,
      PH_SPEC     = 17'h00002,
      PH_WR       = 17'h00004,
      PH_WD       = 17'h00008,
      PH_WDEX     = 17'h00010,
      PH_SUBDW    = 17'h00020,
      PH_SUB      = 17'h00040,
      PH_SUBDEC   = 17'h00080,
      PH_SUBFIN   = 17'h00100,
      PH_MARK     = 17'h00200,
      PH_MARKNEXT = 17'h00400,
      PH_LUM      = 17'h00800,
      PH_LUMI     = 17'h01000,
      PH_LUMIA    = 17'h02000,
      PH_LUMII    = 17'h04000,
      PH_LUMV     = 17'h08000,
      PH_END      = 17'h10000
   } phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [1:0] stellar_type;
      logic [4:0] spectral_class;
      logic [6:0] subclass_tenths;
      logic [3:0] luminosity_class;
      logic [5:0] mark_bits;
      logic       dwarf_repeat_error;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] held_type;
      logic [4:0] held_spectral;
      logic [6:0] held_subclass;
      logic [3:0] held_luminosity;
      logic [5:0] held_marks;
      logic [7:0] previous_char;
      logic       repeat_flag;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:           PH_BEGIN,
      held_type:       TYPE_NORMAL,
      held_spectral:   SPEC_UNKNOWN,
      held_subclass:   7'd0,
      held_luminosity: LUM_UNKNOWN,
      held_marks:      6'd0,
      previous_char:   8'd0,
      repeat_flag:     1'b0
   };

endpackage

@@ sv/scsp_step.sv @@
// ----------------------------------------------------------------------------
// Stellar class string parser character step
// Applies one character to the parser state, with every non-consuming move
// folded in, and forms the result the end-of-string character would give.
// ----------------------------------------------------------------------------
module scsp_step (
   input  scsp_pkg::parse_state_type state_cur,
   input  logic [7:0]                ch,
   output scsp_pkg::parse_state_type state_nxt,
   output scsp_pkg::rsp_type         result
);
   import scsp_pkg::*;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = " ";
   localparam logic [7:0] CH_PLUS  = "+";
   localparam logic [7:0] CH_DOT   = ".";
   localparam logic [7:0] CH_QUERY = "?";
   localparam logic [7:0] CH_ZERO  = "0";

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_lower(logic [7:0] c);
      return (c >= "a") && (c <= "z");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return is_lower(c) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic [4:0] main_class(logic [7:0] c);
      logic [4:0] k;
      case (c)
         "O":     k = SPEC_O;
         "B":     k = SPEC_B;
         "A":     k = SPEC_A;
         "F":     k = SPEC_F;
         "G":     k = SPEC_G;
         "K":     k = SPEC_K;
         "M":     k = SPEC_M;
         "R":     k = SPEC_R;
         "N":     k = SPEC_N;
         "C":     k = SPEC_C;
         "S":     k = SPEC_S;
         "L":     k = SPEC_L;
         "T":     k = SPEC_T;
         "Y":     k = SPEC_Y;
         default: k = SPEC_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] dwarf_class(logic [7:0] c);
      logic [4:0] k;
      case (c)
         "A":     k = SPEC_DA;
         "B":     k = SPEC_DB;
         "C":     k = SPEC_DC;
         "O":     k = SPEC_DO;
         "Q":     k = SPEC_DQ;
         "X":     k = SPEC_DX;
         "Z":     k = SPEC_DZ;
         default: k = SPEC_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] mark_bit(logic [7:0] c);
      logic [5:0] k;
      case (c)
         "f":     k = 6'b000001;
         "h":     k = 6'b000010;
         "m":     k = 6'b000100;
         "p":     k = 6'b001000;
         "e":     k = 6'b010000;
         "z":     k = 6'b100000;
         default: k = 6'b000000;
      endcase
      return k;
   endfunction

   // Entry at the luminosity phase. A '0' ends the parse, and first sets the
   // class to zero if it is still unknown.
   function automatic parse_state_type from_lum(parse_state_type s, logic [7:0] c);
      parse_state_type r;
      r = s;
      if (c == CH_ZERO) begin
         if (s.held_luminosity == LUM_UNKNOWN) r.held_luminosity = LUM_ZERO;
         r.phase = PH_END;
      end else if (c == "I") begin
         r.phase = PH_LUMI;
      end else if (c == "V") begin
         r.phase = PH_LUMV;
      end else if (c == CH_SPACE) begin
         r.phase = PH_LUM;
      end else begin
         r.phase = PH_END;
      end
      return r;
   endfunction

   function automatic parse_state_type from_mark(parse_state_type s, logic [7:0] c);
      parse_state_type r;
      logic [5:0]      k;
      r = s;
      k = mark_bit(c);
      if (k != 6'd0) begin
         r.held_marks = s.held_marks | k;
         r.phase      = PH_MARKNEXT;
      end else if ((c == CH_PLUS) || (c == CH_SPACE)) begin
         r.phase = PH_MARK;
      end else if (c == CH_NUL) begin
         r.phase = PH_END;
      end else begin
         r = from_lum(s, c);
      end
      return r;
   endfunction

   function automatic parse_state_type from_sub(parse_state_type s, logic [7:0] c);
      parse_state_type r;
      logic [6:0]      d;
      r = s;
      d = {3'd0, c[3:0]};
      if (is_digit(c)) begin
         r.held_subclass = (d << 3) + (d << 1);
         r.phase         = PH_SUBDEC;
      end else begin
         r = from_mark(s, c);
      end
      return r;
   endfunction

   function automatic parse_state_type from_spec(parse_state_type s, logic [7:0] c);
      parse_state_type r;
      logic [4:0]      k;
      r = s;
      k = main_class(c);
      if (c == "W") begin
         r.phase = PH_WR;
      end else if (k != SPEC_UNKNOWN) begin
         r.held_spectral = k;
         r.phase         = PH_SUB;
      end else begin
         r.phase = PH_END;
      end
      return r;
   endfunction

   parse_state_type s;
   parse_state_type r;
   logic [4:0]      dk;

   always_comb begin
      s  = state_cur;
      r  = state_cur;
      dk = dwarf_class(ch);
      unique case (s.phase)
         PH_BEGIN: begin
            if (ch == "X") begin
               r.held_type = TYPE_BLACK_HOLE;
               r.phase     = PH_END;
            end else if (ch == "Q") begin
               r.held_type = TYPE_NEUTRON;
               r.phase     = PH_END;
            end else if (ch == "D") begin
               r.held_type     = TYPE_WHITE_DWARF;
               r.held_spectral = SPEC_D;
               r.phase         = PH_WD;
            end else if (ch == "s") begin
               r.held_type = TYPE_NORMAL;
               r.phase     = PH_SUBDW;
            end else if (ch == CH_QUERY) begin
               r.phase = PH_END;
            end else begin
               s.held_type = TYPE_NORMAL;
               r = from_spec(s, ch);
            end
         end
         PH_SPEC: r = from_spec(s, ch);
         PH_WR: begin
            if (ch == "O") begin
               r.held_spectral = SPEC_WO;
               r.phase         = PH_SUB;
            end else if (ch == "N") begin
               r.held_spectral = SPEC_WN;
               r.phase         = PH_SUB;
            end else if (ch == "C") begin
               r.held_spectral = SPEC_WC;
               r.phase         = PH_SUB;
            end else begin
               r.phase = PH_END;
            end
         end
         PH_WD: begin
            if (dk != SPEC_UNKNOWN) begin
               r.held_spectral = dk;
               r.phase         = PH_WDEX;
            end else begin
               s.held_spectral = SPEC_D;
               r.held_spectral = SPEC_D;
               // a non-letter after D is left for the subclass
               if (is_alpha(ch)) r.phase = PH_SUB;
               else r = from_sub(s, ch);
            end
         end
         PH_WDEX: begin
            if (ch == s.previous_char) s.repeat_flag = 1'b1;
            r.repeat_flag = s.repeat_flag;
            if (dk != SPEC_UNKNOWN) r.phase = PH_SUB;
            else r = from_sub(s, ch);
         end
         PH_SUBDW: begin
            if (ch == "d") begin
               r.held_luminosity = LUM_VI;
               r.phase           = PH_SPEC;
            end else begin
               r.phase = PH_END;
            end
         end
         PH_SUB:    r = from_sub(s, ch);
         PH_SUBDEC: begin
            if (ch == CH_DOT) r.phase = PH_SUBFIN;
            else r = from_mark(s, ch);
         end
         PH_SUBFIN: begin
            if (is_digit(ch)) r.held_subclass = s.held_subclass + {3'd0, ch[3:0]};
            r.phase = PH_MARK;
         end
         PH_MARK: r = from_mark(s, ch);
         PH_MARKNEXT: begin
            if (is_lower(ch)) r = from_mark(s, ch);
            else r.phase = PH_END;
         end
         PH_LUM: r = from_lum(s, ch);
         PH_LUMI: begin
            if (ch == "a") begin
               r.phase = PH_LUMIA;
            end else if (ch == "b") begin
               r.held_luminosity = LUM_IB;
               r.phase           = PH_MARK;
            end else if (ch == "I") begin
               r.phase = PH_LUMII;
            end else if (ch == "V") begin
               r.held_luminosity = LUM_IV;
               r.phase           = PH_MARK;
            end else begin
               s.held_luminosity = LUM_I;
               r = from_mark(s, ch);
            end
         end
         PH_LUMIA: begin
            if (ch == CH_PLUS) begin
               r.held_luminosity = LUM_IA_PLUS;
               r.phase           = PH_MARK;
            end else if (ch == "b") begin
               r.held_luminosity = LUM_IAB;
               r.phase           = PH_MARK;
            end else begin
               s.held_luminosity = LUM_IA;
               r = from_mark(s, ch);
            end
         end
         PH_LUMII: begin
            if (ch == "I") begin
               r.held_luminosity = LUM_III;
               r.phase           = PH_MARK;
            end else begin
               s.held_luminosity = LUM_II;
               r = from_mark(s, ch);
            end
         end
         PH_LUMV: begin
            if (ch == "I") begin
               r.held_luminosity = LUM_VI;
               r.phase           = PH_MARK;
            end else begin
               s.held_luminosity = LUM_V;
               r = from_mark(s, ch);
            end
         end
         default: r.phase = PH_END;
      endcase
      r.previous_char = ch;
   end

   assign state_nxt = r;

   // End-of-string character: only the pending luminosity phases still
   // change a field, everything else just ends the parse.
   always_comb begin
      result.stellar_type       = r.held_type;
      result.spectral_class     = r.held_spectral;
      result.subclass_tenths    = r.held_subclass;
      result.luminosity_class   = r.held_luminosity;
      result.mark_bits          = r.held_marks;
      result.dwarf_repeat_error = r.repeat_flag;
      case (r.phase)
         PH_LUMI:  result.luminosity_class = LUM_I;
         PH_LUMIA: result.luminosity_class = LUM_IA;
         PH_LUMII: result.luminosity_class = LUM_II;
         PH_LUMV:  result.luminosity_class = LUM_V;
         default:  result.luminosity_class = r.held_luminosity;
      endcase
   end

endmodule

@@ sv/stellar_class_string_parser_unit.sv @@
// ----------------------------------------------------------------------------
// Stellar class string parser unit
// Result: registered from the accepted last character, via the skid slot if the output is held.
// Throughput: one character word per cycle while the skid slot is empty; state step is one folded pass.
// Reset: synchronous, parser returns to the begin state, output empties.
// ----------------------------------------------------------------------------
module stellar_class_string_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  scsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output scsp_pkg::rsp_type rsp_data
);
   import scsp_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type step_nxt;
   rsp_type         step_result;

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;

   logic req_accept;
   logic produce;

   scsp_step u_step (
      .state_cur (state_ff),
      .ch        (req_data.ch),
      .state_nxt (step_nxt),
      .result    (step_result)
   );

   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign produce    = req_accept && req_data.last;

   always_comb begin
      state_in = state_ff;
      if (req_accept) begin
         // a finished string starts the next one from scratch
         state_in = req_data.last ? STATE_RESET : step_nxt;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (produce) begin
            out_valid_in = 1'b1;
            out_data_in  = step_result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_data_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ sv/stellar_class_string_parser_unit_checker.sv @@
// ----------------------------------------------------------------------------
// Stellar class string parser unit checker
// Port-level properties of the parser unit, bound into the parser unit module.
// ----------------------------------------------------------------------------
`include "stellar_class_string_parser_unit_macros.svh"

module stellar_class_string_parser_unit_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input scsp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input scsp_pkg::rsp_type rsp_data
);
   import scsp_pkg::*;

   `SCSP_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a fresh result word only follows an accepted last character
   `SCSP_ASSERT(a_rsp_from_last, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready && req_data.last))

   // input stalls only with both result slots occupied
   `SCSP_ASSERT(a_stall_when_full, clock, reset, !req_ready, rsp_valid)

   `SCSP_ASSERT(a_field_range, clock, reset, rsp_valid, (rsp_data.spectral_class <= SPEC_DZ) && (rsp_data.luminosity_class <= LUM_VI) && (rsp_data.subclass_tenths <= SUBCLASS_MAX))

   // compact objects end the parse on their first letter
   `SCSP_ASSERT(a_compact_empty, clock, reset, rsp_valid && ((rsp_data.stellar_type == TYPE_NEUTRON) || (rsp_data.stellar_type == TYPE_BLACK_HOLE)), (rsp_data.spectral_class == SPEC_UNKNOWN) && (rsp_data.luminosity_class == LUM_UNKNOWN) && (rsp_data.mark_bits == 6'd0) && !rsp_data.dwarf_repeat_error)

endmodule

bind stellar_class_string_parser_unit stellar_class_string_parser_unit_checker u_checker (.*);

@@ verif/tb_stellar_class_string_parser_unit.sv @@
// ----------------------------------------------------------------------------
// Testbench for the stellar class string parser unit
// Streams classification strings one character word at a time. A scoreboard
// runs its own character state machine per accepted word and checks each
// result word in order. Directed strings hit the special cases, then random
// well-formed strings mixed with byte noise run under changing stall
// patterns, including one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
class parse_scoreboard;

   localparam int FOLD_LIMIT = 16;

   scsp_pkg::parse_state_type st;
   scsp_pkg::rsp_type         expected_classes[$];
   int                        errors;

   function new();
      st = scsp_pkg::STATE_RESET;
      errors = 0;
   endfunction

   function int pending();
      return expected_classes.size();
   endfunction

   function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function bit is_lower(logic [7:0] c);
      return c >= "a" && c <= "z";
   endfunction

   function bit is_alpha(logic [7:0] c);
      return is_lower(c) || (c >= "A" && c <= "Z");
   endfunction

   function logic [4:0] main_class_code(logic [7:0] c);
      case (c)
         "O": return scsp_pkg::SPEC_O;
         "B": return scsp_pkg::SPEC_B;
         "A": return scsp_pkg::SPEC_A;
         "F": return scsp_pkg::SPEC_F;
         "G": return scsp_pkg::SPEC_G;
         "K": return scsp_pkg::SPEC_K;
         "M": return scsp_pkg::SPEC_M;
         "R": return scsp_pkg::SPEC_R;
         "N": return scsp_pkg::SPEC_N;
         "C": return scsp_pkg::SPEC_C;
         "S": return scsp_pkg::SPEC_S;
         "L": return scsp_pkg::SPEC_L;
         "T": return scsp_pkg::SPEC_T;
         "Y": return scsp_pkg::SPEC_Y;
         default: return scsp_pkg::SPEC_UNKNOWN;
      endcase
   endfunction

   function logic [4:0] dwarf_class_code(logic [7:0] c);
      case (c)
         "A": return scsp_pkg::SPEC_DA;
         "B": return scsp_pkg::SPEC_DB;
         "C": return scsp_pkg::SPEC_DC;
         "O": return scsp_pkg::SPEC_DO;
         "Q": return scsp_pkg::SPEC_DQ;
         "X": return scsp_pkg::SPEC_DX;
         "Z": return scsp_pkg::SPEC_DZ;
         default: return scsp_pkg::SPEC_UNKNOWN;
      endcase
   endfunction

   function logic [5:0] mark_flag(logic [7:0] c);
      case (c)
         "f": return 6'h01;
         "h": return 6'h02;
         "m": return 6'h04;
         "p": return 6'h08;
         "e": return 6'h10;
         "z": return 6'h20;
         default: return 6'h00;
      endcase
   endfunction

   // one folded step: keep moving until the character is consumed or parse ends
   function void parse_char(logic [7:0] c, bit at_end);
      bit         used;
      int         moves;
      logic [4:0] k;
      logic [5:0] m;
      used = 1'b0;
      for (moves = 0; moves < FOLD_LIMIT && !used && st.phase != scsp_pkg::PH_END;
           moves++) begin
         case (st.phase)
            scsp_pkg::PH_BEGIN: begin
               if (c == "X") begin
                  st.held_type = scsp_pkg::TYPE_BLACK_HOLE;
                  st.phase = scsp_pkg::PH_END;
               end else if (c == "Q") begin
                  st.held_type = scsp_pkg::TYPE_NEUTRON;
                  st.phase = scsp_pkg::PH_END;
               end else if (c == "D") begin
                  st.held_type = scsp_pkg::TYPE_WHITE_DWARF;
                  st.held_spectral = scsp_pkg::SPEC_D;
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_WD;
               end else if (c == "s") begin
                  st.held_type = scsp_pkg::TYPE_NORMAL;
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_SUBDW;
               end else if (c == "?") begin
                  st.phase = scsp_pkg::PH_END;
               end else begin
                  st.held_type = scsp_pkg::TYPE_NORMAL;
                  st.phase = scsp_pkg::PH_SPEC;
               end
            end
            scsp_pkg::PH_SPEC: begin
               k = main_class_code(c);
               if (c == "W") begin
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_WR;
               end else if (k != scsp_pkg::SPEC_UNKNOWN) begin
                  st.held_spectral = k;
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_SUB;
               end else begin
                  st.phase = scsp_pkg::PH_END;
               end
            end
            scsp_pkg::PH_WR: begin
               if (c == "O" || c == "N" || c == "C") begin
                  st.held_spectral = (c == "O") ? scsp_pkg::SPEC_WO :
                                     (c == "N") ? scsp_pkg::SPEC_WN : scsp_pkg::SPEC_WC;
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_SUB;
               end else begin
                  st.phase = scsp_pkg::PH_END;
               end
            end
            scsp_pkg::PH_WD: begin
               k = dwarf_class_code(c);
               if (k != scsp_pkg::SPEC_UNKNOWN) begin
                  st.held_spectral = k;
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_WDEX;
               end else begin
                  // non-letter after D falls through to the subclass
                  st.held_spectral = scsp_pkg::SPEC_D;
                  used = is_alpha(c);
                  st.phase = scsp_pkg::PH_SUB;
               end
            end
            scsp_pkg::PH_WDEX: begin
               if (c == st.previous_char) st.repeat_flag = 1'b1;
               used = dwarf_class_code(c) != scsp_pkg::SPEC_UNKNOWN;
               st.phase = scsp_pkg::PH_SUB;
            end
            scsp_pkg::PH_SUBDW: begin
               if (c == "d") begin
                  st.held_luminosity = scsp_pkg::LUM_VI;
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_SPEC;
               end else begin
                  st.phase = scsp_pkg::PH_END;
               end
            end
            scsp_pkg::PH_SUB: begin
               if (is_digit(c)) begin
                  st.held_subclass = 7'((c - "0") * 10);
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_SUBDEC;
               end else begin
                  st.phase = scsp_pkg::PH_MARK;
               end
            end
            scsp_pkg::PH_SUBDEC: begin
               if (c == ".") begin
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_SUBFIN;
               end else begin
                  st.phase = scsp_pkg::PH_MARK;
               end
            end
            scsp_pkg::PH_SUBFIN: begin
               // anything after the point is consumed, end-of-string included
               if (is_digit(c)) st.held_subclass = 7'(st.held_subclass + (c - "0"));
               used = 1'b1;
               st.phase = scsp_pkg::PH_MARK;
            end
            scsp_pkg::PH_MARK: begin
               m = mark_flag(c);
               if (m != 6'h00) begin
                  st.held_marks = st.held_marks | m;
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_MARKNEXT;
               end else if (c == "+" || c == " ") begin
                  used = 1'b1;
               end else if (c == 8'h00) begin
                  st.phase = scsp_pkg::PH_END;
               end else begin
                  st.phase = scsp_pkg::PH_LUM;
               end
            end
            scsp_pkg::PH_MARKNEXT: begin
               st.phase = is_lower(c) ? scsp_pkg::PH_MARK : scsp_pkg::PH_END;
            end
            scsp_pkg::PH_LUM: begin
               if (c == "0") begin
                  if (st.held_luminosity == scsp_pkg::LUM_UNKNOWN) begin
                     st.held_luminosity = scsp_pkg::LUM_ZERO;
                     st.phase = scsp_pkg::PH_MARK;
                  end else begin
                     st.phase = scsp_pkg::PH_END;
                  end
               end else if (c == "I") begin
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_LUMI;
               end else if (c == "V") begin
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_LUMV;
               end else if (c == " ") begin
                  used = 1'b1;
               end else begin
                  st.phase = scsp_pkg::PH_END;
               end
            end
            scsp_pkg::PH_LUMI: begin
               if (c == "a") begin
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_LUMIA;
               end else if (c == "b") begin
                  st.held_luminosity = scsp_pkg::LUM_IB;
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_MARK;
               end else if (c == "I") begin
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_LUMII;
               end else if (c == "V") begin
                  st.held_luminosity = scsp_pkg::LUM_IV;
                  used = 1'b1;
                  st.phase = scsp_pkg::PH_MARK;
               end else begin
                  st.held_luminosity = scsp_pkg::LUM_I;
                  st.phase = scsp_pkg::PH_MARK;
               end
            end
            scsp_pkg::PH_LUMIA: begin
               if (c == "+") begin
                  st.held_luminosity = scsp_pkg::LUM_IA_PLUS;
                  used = 1'b1;
               end else if (c == "b") begin
                  st.held_luminosity = scsp_pkg::LUM_IAB;
                  used = 1'b1;
               end else begin
                  st.held_luminosity = scsp_pkg::LUM_IA;
               end
               st.phase = scsp_pkg::PH_MARK;
            end
            scsp_pkg::PH_LUMII: begin
               if (c == "I") begin
                  st.held_luminosity = scsp_pkg::LUM_III;
                  used = 1'b1;
               end else begin
                  st.held_luminosity = scsp_pkg::LUM_II;
               end
               st.phase = scsp_pkg::PH_MARK;
            end
            scsp_pkg::PH_LUMV: begin
               if (c == "I") begin
                  st.held_luminosity = scsp_pkg::LUM_VI;
                  used = 1'b1;
               end else begin
                  st.held_luminosity = scsp_pkg::LUM_V;
               end
               st.phase = scsp_pkg::PH_MARK;
            end
            default: st.phase = scsp_pkg::PH_END;
         endcase
      end
      if ((!used || at_end) && (moves >= FOLD_LIMIT || at_end)) st.phase = scsp_pkg::PH_END;
   endfunction

   function void note_char(scsp_pkg::req_type w);
      scsp_pkg::rsp_type r;
      parse_char(w.ch, 1'b0);
      st.previous_char = w.ch;
      if (w.last) begin
         parse_char(8'h00, 1'b1);
         r.stellar_type       = st.held_type;
         r.spectral_class     = st.held_spectral;
         r.subclass_tenths    = st.held_subclass;
         r.luminosity_class   = st.held_luminosity;
         r.mark_bits          = st.held_marks;
         r.dwarf_repeat_error = st.repeat_flag;
         expected_classes.push_back(r);
         st = scsp_pkg::STATE_RESET;
      end
   endfunction

   function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   function void check_result(scsp_pkg::rsp_type got);
      scsp_pkg::rsp_type want;
      if (expected_classes.size() == 0) begin
         $error("result word with no string pending");
         errors++;
         return;
      end
      want = expected_classes.pop_front();
      compare_field("stellar_type", want.stellar_type, got.stellar_type);
      compare_field("spectral_class", want.spectral_class, got.spectral_class);
      compare_field("subclass_tenths", want.subclass_tenths, got.subclass_tenths);
      compare_field("luminosity_class", want.luminosity_class, got.luminosity_class);
      compare_field("mark_bits", want.mark_bits, got.mark_bits);
      compare_field("dwarf_repeat_error", want.dwarf_repeat_error, got.dwarf_repeat_error);
   endfunction

endclass

module tb_stellar_class_string_parser_unit;

   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_CHARS = 1000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   scsp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   scsp_pkg::rsp_type rsp_data;

   parse_scoreboard sb;
   int              send_idle_pct;
   int              recv_idle_pct;
   int              hold_req;
   int              hold_seen;
   int              hold_left;
   int              chars_sent;

   stellar_class_string_parser_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // receiver: random stalls, plus a long hold-off when asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_seen <= 0;
         hold_left <= 0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_char(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   task automatic send_char(logic [7:0] c, logic l);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{ch: c, last: l};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_chars(logic [7:0] s[$]);
      for (int i = 0; i < s.size(); i++) send_char(s[i], i == s.size() - 1);
   endtask

   task automatic send_text(string t);
      logic [7:0] s[$];
      for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
      send_chars(s);
   endtask

   function automatic logic [7:0] pick_from(string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   // mostly well-formed class strings with random content
   function automatic void build_class_string(ref logic [7:0] s[$]);
      string lums[11] = '{"0", "Ia+", "Ia", "Iab", "Ib", "I", "II", "III", "IV", "V", "VI"};
      string lum;
      int    n;
      case ($urandom_range(0, 9))
         0: begin
            s.push_back("D");
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
               s.push_back(($urandom_range(0, 4) == 0) ? pick_from("abDEqxAZ") :
                           pick_from("ABCOQXZ"));
         end
         1: begin
            s.push_back("W");
            s.push_back(($urandom_range(0, 5) == 0) ? pick_from("ABW1") : pick_from("ONC"));
         end
         2: begin
            s.push_back("s");
            if ($urandom_range(0, 5) != 0) s.push_back("d");
            s.push_back(pick_from("OBAFGKM"));
         end
         3: s.push_back(pick_from("XQ?"));
         default: s.push_back(pick_from("OBAFGKMRNCSLTY"));
      endcase
      if ($urandom_range(0, 9) < 7) begin
         s.push_back(pick_from("0123456789"));
         if ($urandom_range(0, 3) == 0) begin
            s.push_back(".");
            if ($urandom_range(0, 4) != 0) s.push_back(pick_from("0123456789"));
            else if ($urandom_range(0, 1) == 0) s.push_back(pick_from("xV "));
         end
      end
      if ($urandom_range(0, 9) < 6) begin
         if ($urandom_range(0, 4) == 0) s.push_back(" ");
         lum = lums[$urandom_range(0, 10)];
         for (int i = 0; i < lum.len(); i++) s.push_back(lum[i]);
      end
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++)
         s.push_back(($urandom_range(0, 5) == 0) ? pick_from("abk+ 0I") : pick_from("fhmpez"));
      if ($urandom_range(0, 7) == 0) s.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic run_random(int target);
      logic [7:0] s[$];
      int         n;
      while (chars_sent < target) begin
         s = {};
         if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) s.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_class_string(s);
         end
         send_chars(s);
      end
   endtask

   initial begin
      #(8 * 400000);
      $display("tb_stellar_class_string_parser_unit: done, errors");
      $finish;
   end

   initial begin
      int start;
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      send_idle_pct = 15;
      recv_idle_pct = 48;
      hold_req = 0;
      chars_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed strings
      send_text("G2V");
      send_text("DA3");
      send_text("WN7h");
      send_text("sdB");
      send_text("O5Ia+f");
      send_text("B0.5Iab");
      send_text("DAA");
      send_text("D5");
      send_text("X1");
      send_text("Q");
      send_text("?");
      send_text("K3IIIfe");
      send_text("A0 0p");
      send_text("M2V!x");
      send_text("B1.");
      send_text("Y9.9VIz");
      send_text("C2IIm+h");
      send_text("L3IbT");
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b0);
      send_char(8'h80, 1'b1);

      start = chars_sent;
      run_random(start + RANDOM_CHARS / 3);
      send_idle_pct = 48;
      recv_idle_pct = 15;
      run_random(start + 2 * RANDOM_CHARS / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // long receiver hold-off while the sender keeps streaming
      hold_req = hold_req + 1;
      run_random(start + RANDOM_CHARS);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb_stellar_class_string_parser_unit: done, clean");
      else
         $display("tb_stellar_class_string_parser_unit: done, errors");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/scsp_pkg.sv
sv/scsp_step.sv
sv/stellar_class_string_parser_unit.sv
sv/stellar_class_string_parser_unit_checker.sv
verif/tb_stellar_class_string_parser_unit.sv
